/* hw/rtl/console_command_stream_parser_assert.svh */
// Assertion macros for the console command stream parser.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CONSOLE_COMMAND_STREAM_PARSER_ASSERT_SVH
`define CONSOLE_COMMAND_STREAM_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define CCSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCSP_ASSERT_NOW(lbl, ante, cons, msg)
`define CCSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/ccsp_pkg.sv */
`default_nettype none
package ccsp_pkg;

	// Parser phase.
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_LETTER    = 3'd1,
		PH_SKIP      = 3'd2,
		PH_TOK_SPACE = 3'd3,
		PH_TOK_QUOTE = 3'd4,
		PH_ESC_SPACE = 3'd5,
		PH_ESC_QUOTE = 3'd6,
		PH_HALT      = 3'd7
	} phase_t;

	// Command waiting for its arguments.
	typedef enum logic [2:0] {
		CMD_A = 3'd0,
		CMD_C = 3'd1,
		CMD_D = 3'd2,
		CMD_G = 3'd3,
		CMD_O = 3'd4,
		CMD_W = 3'd5
	} cmd_t;

	// Number conversion phase.
	typedef enum logic [2:0] {
		CV_START  = 3'd0,
		CV_SIGNED = 3'd1,
		CV_ZERO   = 3'd2,
		CV_HEXPFX = 3'd3,
		CV_DIGITS = 3'd4,
		CV_DONE   = 3'd5
	} cv_phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC = 2'd0,
		RADIX_OCT = 2'd1,
		RADIX_HEX = 2'd2
	} radix_t;

	// Result action codes.
	typedef enum logic [2:0] {
		ACT_PRINT  = 3'd0,
		ACT_COLOUR = 3'd1,
		ACT_CLEAR  = 3'd2,
		ACT_GOTO   = 3'd3,
		ACT_WAIT   = 3'd4,
		ACT_QUIT   = 3'd5
	} action_t;

	// Control part of the number converter state.
	typedef struct packed {
		cv_phase_t cv_phase;
		logic      negative;
		radix_t    radix;
		logic      overflowed;
	} conv_ctl_t;

	localparam conv_ctl_t CONV_CTL_RESET = '{
		cv_phase:   CV_START,
		negative:   1'b0,
		radix:      RADIX_DEC,
		overflowed: 1'b0
	};

	// Character codes.
	localparam logic [7:0] CH_DASH      = 8'h2D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_X_LOWER   = 8'h78;
	localparam logic [7:0] CH_X_UPPER   = 8'h58;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_A         = 8'h61;
	localparam logic [7:0] CH_C         = 8'h63;
	localparam logic [7:0] CH_D         = 8'h64;
	localparam logic [7:0] CH_G         = 8'h67;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_O         = 8'h6F;
	localparam logic [7:0] CH_Q         = 8'h71;
	localparam logic [7:0] CH_S         = 8'h73;
	localparam logic [7:0] CH_W         = 8'h77;

	// Marks a byte that is no digit in any base.
	localparam logic [5:0] DIGIT_NONE = 6'd63;

	// Tab, line feed, vertical tab, form feed, carriage return and space.
	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	// Digit value of a byte: 0-9, then letters as 10-35.
	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [5:0] d;
		d = DIGIT_NONE;
		if ((c >= 8'h30) && (c <= 8'h39)) begin
			d = 6'(c - 8'h30);
		end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
			d = 6'(c - 8'h61 + 8'd10);
		end else if ((c >= 8'h41) && (c <= 8'h5A)) begin
			d = 6'(c - 8'h41 + 8'd10);
		end
		return d;
	endfunction

	function automatic logic [5:0] base_of(input radix_t r);
		logic [5:0] b;
		case (r)
			RADIX_OCT: b = 6'd8;
			RADIX_HEX: b = 6'd16;
			default:   b = 6'd10;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/ccsp_cmd_if.sv */
`default_nettype none
// Command byte channel.
interface ccsp_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ccsp_res_if.sv */
`default_nettype none
// Result channel.
interface ccsp_res_if;
	logic               valid;
	logic               ready;
	logic        [2:0]  action;
	logic        [7:0]  out_byte;
	logic signed [63:0] value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;

	modport source (output valid, output action, output out_byte, output value,
		output pos_x, output pos_y, input ready);
	modport sink (input valid, input action, input out_byte, input value,
		input pos_x, input pos_y, output ready);
endinterface
`default_nettype wire

/* hw/rtl/console_command_stream_parser.sv */
// A byte is registered on acceptance; its result, if any, is loaded into the output
// register when the byte moves on, and is offered on the result channel from there.
// Throughput: one byte per cycle while no stall holds it, set by the single parser state update.
// A waiting result stalls input only when the next byte also makes a result.
// Reset (arst_n low, asynchronous) clears parser, origin and channel state.
`default_nettype none
module console_command_stream_parser #(
	parameter int TOKEN_LIMIT = 1024,
	parameter int NUM_WIDTH   = 64
) (
	input wire logic    clk,
	input wire logic    arst_n,
	ccsp_cmd_if.sink    cmd_in,
	ccsp_res_if.source  res_out
);

`include "console_command_stream_parser_assert.svh"

	localparam int TLW = $clog2(TOKEN_LIMIT + 1);

	// Input register.
	logic                  valid_s1;
	logic [7:0]            ch_s1;

	// Parser state.
	ccsp_pkg::phase_t      phase_q, phase_d;
	ccsp_pkg::cmd_t        cmd_q, cmd_d;
	logic                  arg_q, arg_d;
	logic [TLW-1:0]        tok_len_q, tok_len_d;
	ccsp_pkg::conv_ctl_t   ctl_q, ctl_d;
	logic [NUM_WIDTH-1:0]  mag_q, mag_d;
	logic [31:0]           first_q, first_d;
	logic [31:0]           org_col_q, org_col_d;
	logic [31:0]           org_row_q, org_row_d;

	// Converter connections.
	ccsp_pkg::conv_ctl_t   cv_in_ctl, cv_out_ctl;
	logic [NUM_WIDTH-1:0]  cv_in_mag, cv_out_mag;
	logic [63:0]           cv_value;

	// Result of the byte in the input register.
	logic                  has_res;
	ccsp_pkg::action_t     r_action;
	logic [7:0]            r_byte;
	logic [63:0]           r_value;
	logic [31:0]           r_x, r_y;
	logic                  do_end, do_store;

	// Output register.
	logic                  res_valid_q;
	ccsp_pkg::action_t     res_action_q;
	logic [7:0]            res_byte_q;
	logic [63:0]           res_value_q;
	logic [31:0]           res_x_q, res_y_q;

	logic                  s1_fire;

	// A new token starts from a clean converter state.
	assign cv_in_ctl = (phase_q == ccsp_pkg::PH_SKIP) ? ccsp_pkg::CONV_CTL_RESET : ctl_q;
	assign cv_in_mag = (phase_q == ccsp_pkg::PH_SKIP) ? '0 : mag_q;

	ccsp_num_conv #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_conv (
		.ch      (ch_s1),
		.cur_ctl (cv_in_ctl),
		.cur_mag (cv_in_mag),
		.nxt_ctl (cv_out_ctl),
		.nxt_mag (cv_out_mag),
		.value   (cv_value)
	);

	// Next parser state and result for the registered byte.
	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		arg_d     = arg_q;
		tok_len_d = tok_len_q;
		ctl_d     = ctl_q;
		mag_d     = mag_q;
		first_d   = first_q;
		org_col_d = org_col_q;
		org_row_d = org_row_q;
		has_res   = 1'b0;
		r_action  = ccsp_pkg::ACT_PRINT;
		r_byte    = '0;
		r_value   = '0;
		r_x       = '0;
		r_y       = '0;
		do_end    = 1'b0;
		do_store  = 1'b0;

		case (phase_q)
			ccsp_pkg::PH_IDLE: begin
				if (ch_s1 == ccsp_pkg::CH_DASH) begin
					phase_d = ccsp_pkg::PH_LETTER;
				end
			end
			ccsp_pkg::PH_LETTER: begin
				phase_d   = ccsp_pkg::PH_SKIP;
				arg_d     = 1'b0;
				tok_len_d = '0;
				ctl_d     = ccsp_pkg::CONV_CTL_RESET;
				mag_d     = '0;
				case (ch_s1)
					ccsp_pkg::CH_A: cmd_d = ccsp_pkg::CMD_A;
					ccsp_pkg::CH_C: cmd_d = ccsp_pkg::CMD_C;
					ccsp_pkg::CH_D: cmd_d = ccsp_pkg::CMD_D;
					ccsp_pkg::CH_G: cmd_d = ccsp_pkg::CMD_G;
					ccsp_pkg::CH_O: cmd_d = ccsp_pkg::CMD_O;
					ccsp_pkg::CH_W: cmd_d = ccsp_pkg::CMD_W;
					ccsp_pkg::CH_N: begin
						phase_d  = ccsp_pkg::PH_IDLE;
						has_res  = 1'b1;
						r_action = ccsp_pkg::ACT_PRINT;
						r_byte   = ccsp_pkg::CH_NEWLINE;
					end
					ccsp_pkg::CH_S: begin
						phase_d  = ccsp_pkg::PH_IDLE;
						has_res  = 1'b1;
						r_action = ccsp_pkg::ACT_CLEAR;
					end
					ccsp_pkg::CH_Q: begin
						phase_d  = ccsp_pkg::PH_HALT;
						has_res  = 1'b1;
						r_action = ccsp_pkg::ACT_QUIT;
					end
					default: phase_d = ccsp_pkg::PH_IDLE;
				endcase
			end
			ccsp_pkg::PH_SKIP: begin
				if (!ccsp_pkg::is_ws(ch_s1)) begin
					// Token starts here; an opening quote is dropped, any other first byte is stored as it is.
					tok_len_d = '0;
					ctl_d     = ccsp_pkg::CONV_CTL_RESET;
					mag_d     = '0;
					if (ch_s1 == ccsp_pkg::CH_QUOTE) begin
						phase_d = ccsp_pkg::PH_TOK_QUOTE;
					end else begin
						phase_d  = ccsp_pkg::PH_TOK_SPACE;
						do_store = 1'b1;
					end
				end
			end
			ccsp_pkg::PH_TOK_SPACE, ccsp_pkg::PH_TOK_QUOTE: begin
				if (ch_s1 == ccsp_pkg::CH_BACKSLASH) begin
					phase_d = (phase_q == ccsp_pkg::PH_TOK_QUOTE) ?
						ccsp_pkg::PH_ESC_QUOTE : ccsp_pkg::PH_ESC_SPACE;
				end else if ((phase_q == ccsp_pkg::PH_TOK_QUOTE) ?
						(ch_s1 == ccsp_pkg::CH_QUOTE) : ccsp_pkg::is_ws(ch_s1)) begin
					do_end = 1'b1;
				end else if (tok_len_q >= TLW'(TOKEN_LIMIT)) begin
					do_end = 1'b1;
				end else begin
					do_store = 1'b1;
				end
			end
			ccsp_pkg::PH_ESC_SPACE, ccsp_pkg::PH_ESC_QUOTE: begin
				phase_d = (phase_q == ccsp_pkg::PH_ESC_QUOTE) ?
					ccsp_pkg::PH_TOK_QUOTE : ccsp_pkg::PH_TOK_SPACE;
				if (tok_len_q >= TLW'(TOKEN_LIMIT)) begin
					do_end = 1'b1;
				end else begin
					do_store = 1'b1;
				end
			end
			default: begin
				phase_d = ccsp_pkg::PH_HALT;
			end
		endcase

		// Take one byte into the token: print it, or feed the converter.
		if (do_store) begin
			tok_len_d = tok_len_d + TLW'(1);
			if (cmd_q == ccsp_pkg::CMD_D) begin
				has_res  = 1'b1;
				r_action = ccsp_pkg::ACT_PRINT;
				r_byte   = ch_s1;
			end else begin
				ctl_d = cv_out_ctl;
				mag_d = cv_out_mag;
			end
		end

		// Close the token and act on the command.
		if (do_end) begin
			phase_d = ccsp_pkg::PH_IDLE;
			case (cmd_q)
				ccsp_pkg::CMD_A: begin
					has_res  = 1'b1;
					r_action = ccsp_pkg::ACT_PRINT;
					r_byte   = cv_value[7:0];
				end
				ccsp_pkg::CMD_C: begin
					has_res  = 1'b1;
					r_action = ccsp_pkg::ACT_COLOUR;
					r_value  = cv_value;
				end
				ccsp_pkg::CMD_W: begin
					has_res  = 1'b1;
					r_action = ccsp_pkg::ACT_WAIT;
					r_value  = cv_value;
				end
				ccsp_pkg::CMD_G, ccsp_pkg::CMD_O: begin
					if (!arg_q) begin
						first_d   = cv_value[31:0];
						arg_d     = 1'b1;
						phase_d   = ccsp_pkg::PH_SKIP;
						tok_len_d = '0;
						ctl_d     = ccsp_pkg::CONV_CTL_RESET;
						mag_d     = '0;
					end else begin
						arg_d = 1'b0;
						if (cmd_q == ccsp_pkg::CMD_O) begin
							org_col_d = first_q;
							org_row_d = cv_value[31:0];
						end else begin
							has_res  = 1'b1;
							r_action = ccsp_pkg::ACT_GOTO;
							r_x      = org_col_q + first_q;
							r_y      = org_row_q + cv_value[31:0];
						end
					end
				end
				default: begin
					has_res = 1'b0;
				end
			endcase
		end
	end

	// The registered byte moves on unless its result would meet a full output.
	assign s1_fire      = valid_s1 && (!has_res || !res_valid_q || res_out.ready);
	assign cmd_in.ready = !valid_s1 || s1_fire;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_in.valid && cmd_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.valid && cmd_in.ready) begin
			ch_s1 <= cmd_in.ch;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ccsp_pkg::PH_IDLE;
			cmd_q     <= ccsp_pkg::CMD_A;
			arg_q     <= 1'b0;
			tok_len_q <= '0;
			ctl_q     <= ccsp_pkg::CONV_CTL_RESET;
			mag_q     <= '0;
			first_q   <= '0;
			org_col_q <= '0;
			org_row_q <= '0;
		end else if (s1_fire) begin
			phase_q   <= phase_d;
			cmd_q     <= cmd_d;
			arg_q     <= arg_d;
			tok_len_q <= tok_len_d;
			ctl_q     <= ctl_d;
			mag_q     <= mag_d;
			first_q   <= first_d;
			org_col_q <= org_col_d;
			org_row_q <= org_row_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && has_res) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && has_res) begin
			res_action_q <= r_action;
			res_byte_q   <= r_byte;
			res_value_q  <= r_value;
			res_x_q      <= r_x;
			res_y_q      <= r_y;
		end
	end

	assign res_out.valid    = res_valid_q;
	assign res_out.action   = res_action_q;
	assign res_out.out_byte = res_byte_q;
	assign res_out.value    = res_value_q;
	assign res_out.pos_x    = res_x_q;
	assign res_out.pos_y    = res_y_q;

	// Checks.
	`CCSP_ASSERT_NEXT(a_halt_sticks, phase_q == ccsp_pkg::PH_HALT, phase_q == ccsp_pkg::PH_HALT, "parser left halt")
	`CCSP_ASSERT_NOW(a_tok_len_max, 1'b1, tok_len_q <= TLW'(TOKEN_LIMIT), "token length beyond limit")
	`CCSP_ASSERT_NEXT(a_byte_held, valid_s1 && !s1_fire, valid_s1 && (ch_s1 == $past(ch_s1)), "stalled byte lost")
	`CCSP_ASSERT_NEXT(a_quit_halts, s1_fire && has_res && (r_action == ccsp_pkg::ACT_QUIT), phase_q == ccsp_pkg::PH_HALT, "quit without halt")

endmodule
`default_nettype wire

/* hw/rtl/ccsp_num_conv.sv */
`default_nettype none
// One step of the base-0 number conversion, and the value of the
// conversion so far, with saturation to the signed NUM_WIDTH range.
module ccsp_num_conv #(
	parameter int NUM_WIDTH = 64
) (
	input  wire logic [7:0]           ch,
	input  wire ccsp_pkg::conv_ctl_t  cur_ctl,
	input  wire logic [NUM_WIDTH-1:0] cur_mag,
	output ccsp_pkg::conv_ctl_t       nxt_ctl,
	output logic [NUM_WIDTH-1:0]      nxt_mag,
	output logic [63:0]               value
);

	localparam int MW = NUM_WIDTH + 5;
	localparam logic [MW-1:0] MAXP = {{6{1'b0}}, {(NUM_WIDTH-1){1'b1}}};
	localparam logic [63:0] MAXP64 = {{(65-NUM_WIDTH){1'b0}}, {(NUM_WIDTH-1){1'b1}}};

	logic [5:0]              dig;
	logic                    do_acc;
	ccsp_pkg::radix_t        acc_radix;
	ccsp_pkg::conv_ctl_t     walk_ctl;
	logic [MW-1:0]           mag_ext;
	logic [MW-1:0]           prod;
	logic [MW-1:0]           lim;
	logic [63:0]             mag64;

	assign dig = ccsp_pkg::digit_of(ch);

	// Phase walk of the conversion.
	always_comb begin
		walk_ctl  = cur_ctl;
		do_acc    = 1'b0;
		acc_radix = cur_ctl.radix;
		case (cur_ctl.cv_phase)
			ccsp_pkg::CV_START, ccsp_pkg::CV_SIGNED: begin
				if ((cur_ctl.cv_phase == ccsp_pkg::CV_START) && ccsp_pkg::is_ws(ch)) begin
					walk_ctl = cur_ctl;
				end else if ((cur_ctl.cv_phase == ccsp_pkg::CV_START)
						&& (ch == ccsp_pkg::CH_PLUS)) begin
					walk_ctl.cv_phase = ccsp_pkg::CV_SIGNED;
				end else if ((cur_ctl.cv_phase == ccsp_pkg::CV_START)
						&& (ch == ccsp_pkg::CH_DASH)) begin
					walk_ctl.negative = 1'b1;
					walk_ctl.cv_phase = ccsp_pkg::CV_SIGNED;
				end else if (ch == ccsp_pkg::CH_ZERO) begin
					walk_ctl.radix    = ccsp_pkg::RADIX_OCT;
					walk_ctl.cv_phase = ccsp_pkg::CV_ZERO;
				end else if ((dig >= 6'd1) && (dig <= 6'd9)) begin
					walk_ctl.radix    = ccsp_pkg::RADIX_DEC;
					acc_radix         = ccsp_pkg::RADIX_DEC;
					do_acc            = 1'b1;
					walk_ctl.cv_phase = ccsp_pkg::CV_DIGITS;
				end else begin
					walk_ctl.cv_phase = ccsp_pkg::CV_DONE;
				end
			end
			ccsp_pkg::CV_ZERO: begin
				if ((ch == ccsp_pkg::CH_X_LOWER) || (ch == ccsp_pkg::CH_X_UPPER)) begin
					walk_ctl.cv_phase = ccsp_pkg::CV_HEXPFX;
				end else if (dig < 6'd8) begin
					do_acc            = 1'b1;
					walk_ctl.cv_phase = ccsp_pkg::CV_DIGITS;
				end else begin
					walk_ctl.cv_phase = ccsp_pkg::CV_DONE;
				end
			end
			ccsp_pkg::CV_HEXPFX: begin
				if (dig < 6'd16) begin
					walk_ctl.radix    = ccsp_pkg::RADIX_HEX;
					acc_radix         = ccsp_pkg::RADIX_HEX;
					do_acc            = 1'b1;
					walk_ctl.cv_phase = ccsp_pkg::CV_DIGITS;
				end else begin
					walk_ctl.cv_phase = ccsp_pkg::CV_DONE;
				end
			end
			ccsp_pkg::CV_DIGITS: begin
				if (dig < ccsp_pkg::base_of(cur_ctl.radix)) begin
					do_acc = 1'b1;
				end else begin
					walk_ctl.cv_phase = ccsp_pkg::CV_DONE;
				end
			end
			default: begin
				walk_ctl = cur_ctl;
			end
		endcase
	end

	// Multiply-accumulate by shifts; overflow when the new magnitude passes the limit.
	assign mag_ext = MW'(cur_mag);
	assign lim     = MAXP + MW'(cur_ctl.negative);

	always_comb begin
		case (acc_radix)
			ccsp_pkg::RADIX_OCT: prod = (mag_ext << 3) + MW'(dig);
			ccsp_pkg::RADIX_HEX: prod = (mag_ext << 4) + MW'(dig);
			default:             prod = (mag_ext << 3) + (mag_ext << 1) + MW'(dig);
		endcase
	end

	always_comb begin
		nxt_ctl = walk_ctl;
		nxt_mag = cur_mag;
		if (do_acc && !cur_ctl.overflowed) begin
			if (prod > lim) begin
				nxt_ctl.overflowed = 1'b1;
			end else begin
				nxt_mag = prod[NUM_WIDTH-1:0];
			end
		end
	end

	// Signed value of the conversion so far.
	always_comb begin
		if (cur_ctl.overflowed) begin
			mag64 = MAXP64 + 64'(cur_ctl.negative);
		end else begin
			mag64 = 64'(cur_mag);
		end
		value = cur_ctl.negative ? (64'd0 - mag64) : mag64;
	end

endmodule
`default_nettype wire
